[rtl/core/phalu_pkg.sv]
`timescale 1ns / 1ps
package phalu_pkg;

    localparam int PHALU_LANES = 4;
    localparam int MAX_LANES   = 4;
    localparam int LANE_W      = 16;
    localparam int WORD_W      = MAX_LANES * LANE_W;
    localparam int FUNC_W      = 3;
    localparam int SIG_W       = 11;
    localparam int MAG_W       = 43;
    localparam int POS_W       = 6;
    localparam int EXP_W       = 9;
    localparam int FRAC_W      = 23;

    localparam logic [7:0] ADD_BASE   = 8'd102;
    localparam logic [7:0] MUL_BASE   = 8'd77;
    localparam logic [EXP_W-1:0] NARROW_LO = 9'd112;
    localparam logic [EXP_W-1:0] NARROW_HI = 9'd142;
    localparam logic [31:0] ROUND_ADD  = 32'd4095;
    localparam logic [15:0] HALF_INF   = 16'h7C00;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ZERO = 3'd0,
        FUNC_ADD  = 3'd1,
        FUNC_SUB  = 3'd2,
        FUNC_MUL  = 3'd3
    } func_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } phalu_adv_t;

endpackage

[rtl/core/phalu_if.sv]
`timescale 1ns / 1ps
interface phalu_in_if;
    logic                           valid;
    logic                           ready;
    logic [phalu_pkg::FUNC_W-1:0]   func;
    logic [phalu_pkg::WORD_W-1:0]   a;
    logic [phalu_pkg::WORD_W-1:0]   b;

    modport source (output valid, func, a, b, input ready);
    modport sink   (input valid, func, a, b, output ready);
endinterface

interface phalu_out_if;
    logic                           valid;
    logic                           ready;
    logic [phalu_pkg::WORD_W-1:0]   result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

[rtl/core/phalu_ctrl.sv]
`timescale 1ns / 1ps
module phalu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output phalu_pkg::phalu_adv_t adv
);
    import phalu_pkg::*;

    logic [4:0] v_reg;
    logic [4:0] v_next;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv.s5 = !v_reg[4] || out_ready;
        adv.s4 = !v_reg[3] || adv.s5;
        adv.s3 = !v_reg[2] || adv.s4;
        adv.s2 = !v_reg[1] || adv.s3;
        adv.s1 = !v_reg[0] || adv.s2;
    end

    always_comb
    begin
        v_next    = v_reg;
        if (adv.s1)
        begin
            v_next[0] = in_valid;
        end
        if (adv.s2)
        begin
            v_next[1] = v_reg[0];
        end
        if (adv.s3)
        begin
            v_next[2] = v_reg[1];
        end
        if (adv.s4)
        begin
            v_next[3] = v_reg[2];
        end
        if (adv.s5)
        begin
            v_next[4] = v_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = adv.s1;
    assign out_valid = v_reg[4];

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("empty first stage refused a word");

    a_hold_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && v_reg[4] && !out_ready) |=> v_reg[3])
        else $error("stage four dropped a word under stall");

    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && !(v_reg[4] && out_ready))
        |=> ($countones(v_reg) == $past($countones(v_reg))))
        else $error("word count changed with no handshake");

endmodule

[rtl/core/phalu_lane.sv]
`timescale 1ns / 1ps
module phalu_lane (
    input  logic                          clk,
    input  phalu_pkg::phalu_adv_t         adv,
    input  logic [phalu_pkg::FUNC_W-1:0]  func,
    input  logic [phalu_pkg::LANE_W-1:0]  a,
    input  logic [phalu_pkg::LANE_W-1:0]  b,
    output logic [phalu_pkg::LANE_W-1:0]  result
);
    import phalu_pkg::*;

    function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    // stage 1: widen, align, multiply
    logic [MAG_W-2:0]   s1_ta_reg, s1_tb_reg;
    logic [2*SIG_W-1:0] s1_prod_reg;
    logic [7:0]         s1_mbase_reg;
    logic               s1_sa_reg, s1_sb_reg, s1_mul_reg, s1_zero_reg;
    // stage 2: signed add
    logic [MAG_W-1:0]   s2_mag_reg;
    logic               s2_sign_reg;
    logic [7:0]         s2_base_reg;
    // stage 3: leading one
    logic [MAG_W-1:0]   s3_mag_reg;
    logic [POS_W-1:0]   s3_pos_reg;
    logic               s3_sign_reg, s3_zero_reg;
    logic [7:0]         s3_base_reg;
    // stage 4: normalize and round
    logic               s4_sign_reg, s4_zero_reg;
    logic [EXP_W-1:0]   s4_exp_reg;
    logic [FRAC_W-1:0]  s4_frac_reg;
    logic [LANE_W-1:0]  s5_res_reg;

    logic [SIG_W-1:0]   ma, mb;
    logic [4:0]         ea, eb;
    logic [MAG_W-1:0]   ta_w, tb_w, mag_next;
    logic               sign_next;
    logic [MAG_W-1:0]   norm;
    logic [24:0]        rmant;
    logic               rinc;
    logic [EXP_W-1:0]   exp_next;
    logic [31:0]        w, r;
    logic [LANE_W-1:0]  res_next;

    assign ea = a[14:10];
    assign eb = b[14:10];
    assign ma = {1'b1, a[9:0]};
    assign mb = {1'b1, b[9:0]};

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            s1_ta_reg    <= (MAG_W-1)'(ma) << ea;
            s1_tb_reg    <= (MAG_W-1)'(mb) << eb;
            s1_prod_reg  <= ma * mb;
            s1_mbase_reg <= 8'(ea) + 8'(eb) + MUL_BASE;
            s1_sa_reg    <= a[15];
            s1_sb_reg    <= b[15] ^ (func == FUNC_SUB);
            s1_mul_reg   <= (func == FUNC_MUL);
            s1_zero_reg  <= !(func == FUNC_ADD || func == FUNC_SUB || func == FUNC_MUL);
        end
    end

    always_comb
    begin
        ta_w = {1'b0, s1_ta_reg};
        tb_w = {1'b0, s1_tb_reg};
        if (s1_zero_reg)
        begin
            mag_next  = '0;
            sign_next = 1'b0;
        end
        else if (s1_mul_reg)
        begin
            mag_next  = MAG_W'(s1_prod_reg);
            sign_next = s1_sa_reg ^ s1_sb_reg;
        end
        else if (s1_sa_reg == s1_sb_reg)
        begin
            mag_next  = ta_w + tb_w;
            sign_next = s1_sa_reg;
        end
        else if (ta_w >= tb_w)
        begin
            mag_next  = ta_w - tb_w;
            sign_next = s1_sa_reg;
        end
        else
        begin
            mag_next  = tb_w - ta_w;
            sign_next = s1_sb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            s2_mag_reg  <= mag_next;
            s2_sign_reg <= sign_next;
            s2_base_reg <= s1_mul_reg ? s1_mbase_reg : ADD_BASE;
        end
        if (adv.s3)
        begin
            s3_mag_reg  <= s2_mag_reg;
            s3_pos_reg  <= lead_pos(s2_mag_reg);
            s3_zero_reg <= (s2_mag_reg == '0);
            s3_sign_reg <= s2_sign_reg;
            s3_base_reg <= s2_base_reg;
        end
    end

    // put the leading one at the top, round to 24 bits, nearest even
    always_comb
    begin
        norm     = s3_mag_reg << (POS_W'(MAG_W-1) - s3_pos_reg);
        rinc     = norm[MAG_W-25] && ((|norm[MAG_W-26:0]) || norm[MAG_W-24]);
        rmant    = {1'b0, norm[MAG_W-1:MAG_W-24]} + 25'(rinc);
        exp_next = EXP_W'(s3_base_reg) + EXP_W'(s3_pos_reg) + EXP_W'(rmant[24]);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            s4_sign_reg <= s3_sign_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_exp_reg  <= exp_next;
            s4_frac_reg <= rmant[22:0];
        end
    end

    // narrow back to half
    always_comb
    begin
        w = {s4_sign_reg, s4_exp_reg[7:0], s4_frac_reg};
        r = w + ROUND_ADD;
        if (s4_zero_reg || s4_exp_reg < NARROW_LO)
        begin
            res_next = '0;
        end
        else if (s4_exp_reg > NARROW_HI)
        begin
            res_next = {s4_sign_reg, 15'd0} | HALF_INF;
        end
        else
        begin
            res_next = {r[31:30], r[26:13]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            s5_res_reg <= res_next;
        end
    end

    assign result = s5_res_reg;

endmodule

[rtl/core/packed_half_float_alu_unit.sv]
`timescale 1ns / 1ps
// Throughput: one word per cycle while out_ch.ready is high; each stage holds its
// word while the stage after it is full and stalled, so a stall costs nothing but time.
// Reset: clears the stage valid bits only; the datapath registers are not reset.
// Stages: align and multiply, signed add, leading-one search, round, narrow.
module packed_half_float_alu_unit #(
    parameter int LANES = phalu_pkg::PHALU_LANES
) (
    input  logic         clk,
    input  logic         rst_n,
    phalu_in_if.sink     in_ch,
    phalu_out_if.source  out_ch
);
    import phalu_pkg::*;

    phalu_adv_t adv;
    logic [WORD_W-1:0] res_word;

    // valid bits and per-stage advance
    phalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .adv       (adv)
    );

    // one datapath per half lane; unused lanes read as zero
    for (genvar i = 0; i < MAX_LANES; i++)
    begin : g_lane
        if (i < LANES)
        begin : g_on
            phalu_lane u_lane (
                .clk    (clk),
                .adv    (adv),
                .func   (in_ch.func),
                .a      (in_ch.a[i*LANE_W +: LANE_W]),
                .b      (in_ch.b[i*LANE_W +: LANE_W]),
                .result (res_word[i*LANE_W +: LANE_W])
            );
        end
        else
        begin : g_off
            assign res_word[i*LANE_W +: LANE_W] = '0;
        end
    end

    assign out_ch.result = res_word;

endmodule

[tb/packed_half_float_alu_unit_test.sv]
`timescale 1ns / 1ps
module packed_half_float_alu_unit_test;
    import phalu_pkg::*;

    // One input word: operation and two packed operands.
    typedef struct packed {
        func_t             func;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_word_t;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_WORDS = 1000;

    logic clk;
    logic rst_n;

    phalu_in_if  in_ch ();
    phalu_out_if out_ch ();

    packed_half_float_alu_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    alu_word_t         pending_words[$];
    logic [WORD_W-1:0] expected_results[$];
    int                failures;
    int                idle_cycles;
    bit                in_took;
    bit                out_took;
    int                in_wait;
    int                out_wait;
    bit                in_burst;
    bit                out_burst;
    int                in_count;
    int                out_count;

    always #2 clk = ~clk;

    // Widen a half lane by rebiasing its exponent; specials are not special here.
    function automatic logic [31:0] widen_half(logic [15:0] h);
        return {h[15], 31'b0} | ((32'(h[14:0]) + 32'h1C000) << 13);
    endfunction

    // Normalize a magnitude to 24 bits with round to nearest even and pack it.
    // The biased exponent is the leading-one position plus exp_base.
    function automatic logic [31:0] round_pack(logic s, logic [127:0] m, int exp_base);
        int           lead;
        int           sh;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        int           biased;
        lead = 0;
        for (int i = 0; i < 128; i++)
            if (m[i])
                lead = i;
        biased = lead + exp_base;
        if (lead <= 23) begin
            q = m << (23 - lead);
        end
        else begin
            sh   = lead - 23;
            q    = m >> sh;
            rem  = m & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 128'd1;
            if (q[24]) begin
                q = q >> 1;
                biased++;
            end
        end
        return {s, biased[7:0], q[22:0]};
    endfunction

    // Single-precision add of two normal operands; for a subtract the caller flips y's sign first.
    function automatic logic [31:0] single_add(logic [31:0] x, logic [31:0] y);
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] mag;
        logic         s;
        int           ex;
        int           ey;
        int           emax;
        ex = int'(x[30:23]);
        ey = int'(y[30:23]);
        mx = 128'({1'b1, x[22:0]}) << 40;
        my = 128'({1'b1, y[22:0]}) << 40;
        emax = (ex > ey) ? ex : ey;
        mx = mx >> (emax - ex);
        my = my >> (emax - ey);
        if (x[31] == y[31]) begin
            mag = mx + my;
            s   = x[31];
        end
        else if (mx > my) begin
            mag = mx - my;
            s   = x[31];
        end
        else if (my > mx) begin
            mag = my - mx;
            s   = y[31];
        end
        else begin
            return 32'd0;
        end
        return round_pack(s, mag, emax - 63);
    endfunction

    function automatic logic [31:0] single_mul(logic [31:0] x, logic [31:0] y);
        logic [127:0] prod;
        prod = 128'({1'b1, x[22:0]}) * 128'({1'b1, y[22:0]});
        return round_pack(x[31] ^ y[31], prod, int'(x[30:23]) + int'(y[30:23]) - 127 - 46);
    endfunction

    // Narrow back: flush below range, saturate above it, else add 4095 and cut.
    function automatic logic [15:0] narrow_single(logic [31:0] w);
        int          e;
        logic [31:0] r;
        e = int'(w[30:23]) - 112;
        if (e < 0)
            return 16'd0;
        if (e > 30)
            return {w[31], 15'h0000} | HALF_INF;
        r = w + ROUND_ADD;
        return {r[31:30], r[26:13]};
    endfunction

    function automatic logic [WORD_W-1:0] packed_result(alu_word_t w);
        logic [WORD_W-1:0] res;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        res = '0;
        for (int i = 0; i < PHALU_LANES; i++) begin
            x = widen_half(w.a[16*i +: 16]);
            y = widen_half(w.b[16*i +: 16]);
            case (w.func)
                FUNC_ADD: z = single_add(x, y);
                FUNC_SUB: z = single_add(x, {~y[31], y[30:0]});
                FUNC_MUL: z = single_mul(x, y);
                default:  z = 32'd0;
            endcase
            res[16*i +: 16] = narrow_single(z);
        end
        return res;
    endfunction

    // Draw a gap: long runs with none, the rest uniform over the full range.
    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [15:0] random_lane();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            // keep exponents near the middle so sums cancel and round
            1:       return {1'($urandom), 5'($urandom_range(12, 18)), 10'($urandom)};
            2:       return {1'($urandom), 5'($urandom_range(0, 31)), 10'h3FF};
            default: return {1'($urandom), 5'($urandom_range(0, 31)), 10'($urandom)};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {random_lane(), random_lane(), random_lane(), random_lane()};
    endfunction

    // Accept and check at the rising edge; the watchdog also lives here.
    always @(posedge clk) begin
        alu_word_t taken;
        logic [WORD_W-1:0] want;
        in_took  = rst_n && in_ch.valid && in_ch.ready;
        out_took = rst_n && out_ch.valid && out_ch.ready;
        if (in_took) begin
            taken.func = func_t'(in_ch.func);
            taken.a    = in_ch.a;
            taken.b    = in_ch.b;
            expected_results.push_back(packed_result(taken));
            in_count++;
        end
        if (out_took) begin
            out_count++;
            if (expected_results.size() == 0) begin
                $error("result: no word expected, actual %h", out_ch.result);
                failures++;
            end
            else begin
                want = expected_results.pop_front();
                if (out_ch.result !== want) begin
                    $error("result: expected %h actual %h", want, out_ch.result);
                    failures++;
                end
            end
        end
        if (in_took || out_took || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("packed_half_float_alu_unit: mismatch");
            $finish;
        end
    end

    // Input driver: hold a word until taken, then idle for the drawn gap.
    always @(negedge clk) begin
        alu_word_t nxt;
        if (rst_n) begin
            if (in_count % 97 == 0)
                in_burst = ($urandom_range(0, 2) == 0);
            if (in_ch.valid && !in_took) begin
                // hold the current word
            end
            else if (in_wait > 0) begin
                in_ch.valid <= 1'b0;
                in_wait--;
            end
            else if (pending_words.size() > 0) begin
                nxt = pending_words.pop_front();
                in_ch.func  <= nxt.func;
                in_ch.a     <= nxt.a;
                in_ch.b     <= nxt.b;
                in_ch.valid <= 1'b1;
                in_wait = draw_gap(in_burst);
            end
            else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output side: stall ready for a drawn gap after each result word.
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_count % 89 == 0)
                out_burst = ($urandom_range(0, 2) == 0);
            if (out_ch.ready && !out_took) begin
                // keep ready up until a word moves
            end
            else if (out_wait > 0) begin
                out_ch.ready <= 1'b0;
                out_wait--;
            end
            else begin
                out_ch.ready <= 1'b1;
                out_wait = draw_gap(out_burst);
            end
        end
    end

    task automatic queue_word(logic [2:0] f, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        alu_word_t w;
        w.func = func_t'(f);
        w.a    = a;
        w.b    = b;
        pending_words.push_back(w);
    endtask

    initial begin
        logic [2:0] f;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_ZERO;
        in_ch.a      = '0;
        in_ch.b      = '0;
        out_ch.ready = 1'b0;
        failures     = 0;
        idle_cycles  = 0;
        in_wait      = 0;
        out_wait     = 0;
        in_count     = 0;
        out_count    = 0;
        in_burst     = 1'b0;
        out_burst    = 1'b0;

        // Directed: every code, field extremes, and each odd lane class.
        // Zeros, denormals, infinities and NaNs all widen as plain normals.
        for (int i = 0; i < 8; i++)
            queue_word(3'(i), 64'h7FFF_8000_7C00_3C00, 64'hFFFF_0001_7E00_3C00);
        queue_word(FUNC_ADD, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        queue_word(FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(FUNC_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // overflow to infinity with the sign kept
        queue_word(FUNC_MUL, 64'h7BFF_FBFF_7C00_FC00, 64'h7BFF_7BFF_7C00_7C00);
        // underflow to zero, sign dropped
        queue_word(FUNC_MUL, 64'h0001_8001_0400_8400, 64'h0001_0001_0400_0400);
        // exact cancellation gives positive zero
        queue_word(FUNC_SUB, 64'h3C00_BC00_7BFF_0001, 64'h3C00_BC00_7BFF_0001);
        // rounding carries into the exponent
        queue_word(FUNC_ADD, 64'h3FFF_43FF_07FF_BBFF, 64'h0001_0001_0001_8001);
        // widely spaced exponents in a sum
        queue_word(FUNC_ADD, 64'h7BFF_0000_FBFF_0001, 64'h0000_7BFF_0001_FBFF);
        queue_word(FUNC_SUB, 64'hAAAA_5555_1234_FEDC, 64'h5555_AAAA_4321_0123);

        // Random: mostly real operations, a few of the zero codes.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            f = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 3));
            queue_word(f, random_word(), random_word());
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("packed_half_float_alu_unit: match");
        end
        else begin
            $display("packed_half_float_alu_unit: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/phalu_pkg.sv
rtl/core/phalu_if.sv
rtl/core/phalu_ctrl.sv
rtl/core/phalu_lane.sv
rtl/core/packed_half_float_alu_unit.sv
tb/packed_half_float_alu_unit_test.sv
